[hw/rtl/csh_pkg.sv]
// Package for the complex sample histogram: sizes, action codes, FSM states
// and the controller/datapath command and status structs. No dependencies.
package csh_pkg;
	localparam int MaxBins = 256;
	localparam int BinW = $clog2(MaxBins);
	localparam int NbW = BinW + 1;

	typedef enum logic [1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_READ   = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	localparam logic [0:0] CFG_BIN_WIDTH = 1'b0;
	localparam logic [0:0] CFG_NUM_BINS  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SQRT,
		ST_DIV,
		ST_RD_MAG,
		ST_WR_MAG,
		ST_RD_RE,
		ST_WR_RE,
		ST_RD_IM,
		ST_WR_IM,
		ST_READ,
		ST_READ_OUT
	} state_t;

	typedef enum logic [1:0] {
		SEL_MAG = 2'd0,
		SEL_RE  = 2'd1,
		SEL_IM  = 2'd2
	} sel_t;

	typedef struct packed {
		logic load;
		logic sqrt_step;
		logic div_start;
		logic div_step;
		logic clr_step;
		logic rd_en;
		logic wr_en;
		sel_t sel;
		logic rd_read;
		logic snap_bump;
		logic snap_clr;
		logic out_valid;
	} cmd_t;

	typedef struct packed {
		logic sqrt_done;
		logic div_done;
		logic clr_done;
	} stat_t;
endpackage

[hw/rtl/csh_ctrl.sv]
// Controller state machine for the complex sample histogram.
// Depends on csh_pkg; drives command structs to csh_dp.
module csh_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [1:0]       action,
	input  csh_pkg::stat_t   stat,
	output csh_pkg::cmd_t    cmd,
	output logic             busy
);
	csh_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= csh_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			csh_pkg::ST_IDLE: begin
				if (start) begin
					case (action)
						csh_pkg::ACT_SAMPLE: state_d = csh_pkg::ST_SQRT;
						csh_pkg::ACT_READ:   state_d = csh_pkg::ST_READ;
						csh_pkg::ACT_CLEAR:  state_d = csh_pkg::ST_CLEAR;
						default:             state_d = csh_pkg::ST_IDLE;
					endcase
				end
			end
			csh_pkg::ST_CLEAR:    if (stat.clr_done) state_d = csh_pkg::ST_IDLE;
			csh_pkg::ST_SQRT:     if (stat.sqrt_done) state_d = csh_pkg::ST_DIV;
			csh_pkg::ST_DIV:      if (stat.div_done) state_d = csh_pkg::ST_RD_MAG;
			csh_pkg::ST_RD_MAG:   state_d = csh_pkg::ST_WR_MAG;
			csh_pkg::ST_WR_MAG:   state_d = csh_pkg::ST_RD_RE;
			csh_pkg::ST_RD_RE:    state_d = csh_pkg::ST_WR_RE;
			csh_pkg::ST_WR_RE:    state_d = csh_pkg::ST_RD_IM;
			csh_pkg::ST_RD_IM:    state_d = csh_pkg::ST_WR_IM;
			csh_pkg::ST_WR_IM:    state_d = csh_pkg::ST_IDLE;
			csh_pkg::ST_READ:     state_d = csh_pkg::ST_READ_OUT;
			csh_pkg::ST_READ_OUT: state_d = csh_pkg::ST_IDLE;
			default:              state_d = csh_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.sel = csh_pkg::SEL_MAG;
		busy = (state_q != csh_pkg::ST_IDLE);
		case (state_q)
			csh_pkg::ST_IDLE: begin
				cmd.load = start;
				cmd.snap_clr = start && (action == csh_pkg::ACT_CLEAR);
			end
			csh_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
			csh_pkg::ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cmd.div_start = stat.sqrt_done;
			end
			csh_pkg::ST_DIV: cmd.div_step = 1'b1;
			csh_pkg::ST_RD_MAG: cmd.rd_en = 1'b1;
			csh_pkg::ST_WR_MAG: cmd.wr_en = 1'b1;
			csh_pkg::ST_RD_RE: begin
				cmd.rd_en = 1'b1;
				cmd.sel = csh_pkg::SEL_RE;
			end
			csh_pkg::ST_WR_RE: begin
				cmd.wr_en = 1'b1;
				cmd.sel = csh_pkg::SEL_RE;
			end
			csh_pkg::ST_RD_IM: begin
				cmd.rd_en = 1'b1;
				cmd.sel = csh_pkg::SEL_IM;
			end
			csh_pkg::ST_WR_IM: begin
				cmd.wr_en = 1'b1;
				cmd.sel = csh_pkg::SEL_IM;
				cmd.snap_bump = 1'b1;
			end
			csh_pkg::ST_READ: cmd.rd_read = 1'b1;
			csh_pkg::ST_READ_OUT: cmd.out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule

[hw/rtl/csh_dp.sv]
// Datapath for the complex sample histogram: square root, bin divider, three
// count memories and the snapshot counter. Depends on csh_pkg.
module csh_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  csh_pkg::cmd_t              cmd,
	output csh_pkg::stat_t             stat,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [30:0]                cfg_data,
	input  logic [31:0]                sample_re,
	input  logic [31:0]                sample_im,
	input  logic                       last_of_snapshot,
	input  logic [7:0]                 read_bin,
	output logic [31:0]                magnitude_count,
	output logic [31:0]                real_count,
	output logic [31:0]                imag_count,
	output logic [31:0]                snapshots_seen
);
	localparam int BinW = csh_pkg::BinW;
	localparam int NbW = csh_pkg::NbW;

	logic [30:0] bin_width_q;
	logic [8:0]  num_bins_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width_q <= 31'd65536;
			num_bins_q <= 9'd256;
		end else if (cfg_we) begin
			if (cfg_index == csh_pkg::CFG_BIN_WIDTH) bin_width_q <= cfg_data;
			else num_bins_q <= cfg_data[8:0];
		end
	end

	// Active bin count, clamped to 1..MaxBins.
	logic [NbW-1:0] nb;
	always_comb begin
		if (num_bins_q == 9'd0) nb = NbW'(1);
		else if (32'(num_bins_q) > 32'(csh_pkg::MaxBins)) nb = NbW'(csh_pkg::MaxBins);
		else nb = NbW'(num_bins_q);
	end

	// Operand capture.
	logic [31:0] abs_re_q, abs_im_q;
	logic        last_q;
	logic [BinW-1:0] rbin_q;
	logic [63:0] rem_q, bit_q, root_q;

	function automatic logic [31:0] abs32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	// One 32x32 product per operand is registered in the first sqrt cycle.
	logic [63:0] sq_re_s1, sq_im_s1;
	logic        sq_pend_q;
	logic        sq_first_q;

	// Square root: one bit pair per cycle, 32 steps after the load cycle.
	logic [5:0] sq_cnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_cnt_q <= '0;
			sq_pend_q <= 1'b0;
		end else if (cmd.load) begin
			sq_cnt_q <= '0;
			sq_pend_q <= 1'b1;
		end else if (cmd.sqrt_step) begin
			if (sq_pend_q) sq_pend_q <= 1'b0;
			else if (!sq_first_q) sq_cnt_q <= sq_cnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			abs_re_q <= abs32(sample_re);
			abs_im_q <= abs32(sample_im);
			last_q <= last_of_snapshot;
			rbin_q <= read_bin[BinW-1:0];
		end
		if (cmd.sqrt_step && sq_pend_q) begin
			sq_re_s1 <= 64'(abs_re_q) * 64'(abs_re_q);
			sq_im_s1 <= 64'(abs_im_q) * 64'(abs_im_q);
		end
	end

	logic [64:0] sum_w;
	assign sum_w = 65'(sq_re_s1) + 65'(sq_im_s1);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_first_q <= 1'b0;
		else sq_first_q <= cmd.sqrt_step && sq_pend_q;
	end

	logic [63:0] rb_w;
	assign rb_w = root_q + bit_q;
	// Root after the current step. The last step and div_start share a cycle,
	// so the magnitude divider loads this value.
	logic [63:0] root_nx_w;
	assign root_nx_w = (rem_q >= rb_w) ? ((root_q >> 1) + bit_q) : (root_q >> 1);
	always_ff @(posedge clk) begin
		if (sq_first_q) begin
			rem_q <= sum_w[63:0];
			root_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (cmd.sqrt_step && !sq_pend_q) begin
			if (rem_q >= rb_w) rem_q <= rem_q - rb_w;
			root_q <= root_nx_w;
			bit_q <= bit_q >> 2;
		end
	end
	assign stat.sqrt_done = cmd.sqrt_step && !sq_pend_q && !sq_first_q &&
		(sq_cnt_q == 6'd31);

	// Three restoring dividers share one counter; quotient bits beyond BinW
	// only mark saturation.
	logic [31:0] dq_q [3];
	logic [31:0] dn_q [3];
	logic [31:0] dr_q [3];
	logic [5:0]  dcnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dcnt_q <= '0;
		else if (cmd.div_start) dcnt_q <= '0;
		else if (cmd.div_step) dcnt_q <= dcnt_q + 6'd1;
	end
	assign stat.div_done = cmd.div_step && (dcnt_q == 6'd31);

	for (genvar g = 0; g < 3; g++) begin : g_div
		logic [32:0] tr;
		assign tr = {dr_q[g], dn_q[g][31]};
		always_ff @(posedge clk) begin
			if (cmd.div_start) begin
				dn_q[g] <= (g == 0) ? root_nx_w[31:0] : ((g == 1) ? abs_re_q : abs_im_q);
				dr_q[g] <= '0;
				dq_q[g] <= '0;
			end else if (cmd.div_step) begin
				dn_q[g] <= {dn_q[g][30:0], 1'b0};
				if (tr >= {2'b00, bin_width_q}) begin
					dr_q[g] <= 32'(tr - {2'b00, bin_width_q});
					dq_q[g] <= {dq_q[g][30:0], 1'b1};
				end else begin
					dr_q[g] <= tr[31:0];
					dq_q[g] <= {dq_q[g][30:0], 1'b0};
				end
			end
		end
	end

	function automatic logic [BinW-1:0] clampq(input logic [31:0] q,
		input logic zw, input logic [NbW-1:0] n);
		logic [NbW-1:0] last;
		last = n - NbW'(1);
		if (zw || q >= 32'(last)) return last[BinW-1:0];
		return q[BinW-1:0];
	endfunction

	logic zw;
	assign zw = (bin_width_q == 31'd0);
	logic [BinW-1:0] idx;
	always_comb begin
		case (cmd.sel)
			csh_pkg::SEL_RE: idx = clampq(dq_q[1], zw, nb);
			csh_pkg::SEL_IM: idx = clampq(dq_q[2], zw, nb);
			default:         idx = clampq(dq_q[0], zw, nb);
		endcase
	end

	// Clear sweep counter.
	logic [NbW-1:0] clr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.load) clr_q <= '0;
		else if (cmd.clr_step) clr_q <= clr_q + NbW'(1);
	end
	assign stat.clr_done = cmd.clr_step && (clr_q == NbW'(csh_pkg::MaxBins - 1));

	// Count memories. Reset leaves them unknown; a sweep follows reset.
	logic [31:0] mem_m [csh_pkg::MaxBins];
	logic [31:0] mem_r [csh_pkg::MaxBins];
	logic [31:0] mem_i [csh_pkg::MaxBins];
	logic [31:0] rd_m_q, rd_r_q, rd_i_q;
	logic [BinW-1:0] widx_q;
	logic [31:0] inc_w;
	logic [31:0] cur_w;

	always_comb begin
		case (cmd.sel)
			csh_pkg::SEL_RE: cur_w = rd_r_q;
			csh_pkg::SEL_IM: cur_w = rd_i_q;
			default:         cur_w = rd_m_q;
		endcase
	end
	assign inc_w = (cur_w == 32'hFFFF_FFFF) ? cur_w : cur_w + 32'd1;

	logic [BinW-1:0] raddr;
	assign raddr = cmd.rd_read ? rbin_q : idx;

	always_ff @(posedge clk) begin
		if (cmd.rd_en || cmd.rd_read) begin
			rd_m_q <= mem_m[raddr];
			rd_r_q <= mem_r[raddr];
			rd_i_q <= mem_i[raddr];
			widx_q <= raddr;
		end
		if (cmd.clr_step) begin
			mem_m[clr_q[BinW-1:0]] <= '0;
			mem_r[clr_q[BinW-1:0]] <= '0;
			mem_i[clr_q[BinW-1:0]] <= '0;
		end else if (cmd.wr_en) begin
			case (cmd.sel)
				csh_pkg::SEL_RE: mem_r[widx_q] <= inc_w;
				csh_pkg::SEL_IM: mem_i[widx_q] <= inc_w;
				default:         mem_m[widx_q] <= inc_w;
			endcase
		end
	end

	logic [31:0] snap_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) snap_q <= '0;
		else if (cmd.snap_clr) snap_q <= '0;
		else if (cmd.snap_bump && last_q && snap_q != 32'hFFFF_FFFF)
			snap_q <= snap_q + 32'd1;
	end

	assign magnitude_count = rd_m_q;
	assign real_count = rd_r_q;
	assign imag_count = rd_i_q;
	assign snapshots_seen = snap_q;
endmodule

[hw/rtl/complex_sample_histogram_top.sv]
// Top level of the complex sample histogram.
// Depends on csh_pkg, csh_ctrl and csh_dp.

// A request is taken when start is high and busy low. After a sample request
// is taken, busy stays high through the squares, the square-root load, the
// bit-pair square root of the 64-bit sum of squares, the three shared-step
// restoring divisions by the bin width, and the read-modify-write of the
// three single-port count memories. A read keeps busy high through the
// ST_READ and ST_READ_OUT states, and its result appears in ST_READ_OUT for
// exactly one cycle with done high; the receiver cannot stall it. A clear
// keeps busy high while it sweeps all 256 memory rows, one row per cycle.
// After reset the block runs the same clearing pass with busy high.
// Configuration writes are taken at any time but must only be issued while
// the block is idle.
module complex_sample_histogram_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic signed [31:0] sample_re,
	input  logic signed [31:0] sample_im,
	input  logic        last_of_snapshot,
	input  logic [7:0]  read_bin,
	output logic        done,
	output logic [31:0] magnitude_count,
	output logic [31:0] real_count,
	output logic [31:0] imag_count,
	output logic [31:0] snapshots_seen,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [30:0] cfg_data
);
	csh_pkg::cmd_t  cmd, ccmd;
	csh_pkg::stat_t stat;
	logic           cbusy;

	// Power-up clearing pass: the memories are swept once after reset.
	logic init_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) init_q <= 1'b1;
		else if (stat.clr_done) init_q <= 1'b0;
	end

	csh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start && !init_q), .action(action),
		.stat(stat), .cmd(ccmd), .busy(cbusy)
	);

	always_comb begin
		cmd = ccmd;
		if (init_q) cmd.clr_step = 1'b1;
	end
	assign busy = cbusy || init_q;

	csh_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.sample_re(sample_re), .sample_im(sample_im),
		.last_of_snapshot(last_of_snapshot), .read_bin(read_bin),
		.magnitude_count(magnitude_count), .real_count(real_count),
		.imag_count(imag_count), .snapshots_seen(snapshots_seen)
	);

	assign done = cmd.out_valid;

`ifndef ASSERT_OFF
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result outside a request");
	a_no_start_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !cmd.load) else $error("request taken during clearing");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result held longer than one cycle");
`endif
endmodule

[test/tb_complex_sample_histogram_top.sv]
// Self-checking testbench for complex_sample_histogram_top.
// Depends on csh_pkg and the RTL of the block; it reads nothing else.
// A scoreboard model predicts each read result and a monitor compares them.

module tb_complex_sample_histogram_top;
	import csh_pkg::*;

	// One request as the driver presents it.
	typedef struct {
		action_t     act;
		logic [31:0] re;
		logic [31:0] im;
		logic        last;
		logic [7:0]  rbin;
	} request_t;

	// One read result as the block should return it.
	typedef struct {
		logic [31:0] mag;
		logic [31:0] re;
		logic [31:0] im;
		logic [31:0] snaps;
	} bin_read_t;

	localparam int IdleLimit = 4000;
	localparam int SettleCycles = 300;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  action;
	logic signed [31:0] sample_re;
	logic signed [31:0] sample_im;
	logic        last_of_snapshot;
	logic [7:0]  read_bin;
	logic        done;
	logic [31:0] magnitude_count;
	logic [31:0] real_count;
	logic [31:0] imag_count;
	logic [31:0] snapshots_seen;
	logic        cfg_we;
	logic        cfg_index;
	logic [30:0] cfg_data;

	complex_sample_histogram_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .sample_re(sample_re), .sample_im(sample_im),
		.last_of_snapshot(last_of_snapshot), .read_bin(read_bin),
		.done(done), .magnitude_count(magnitude_count), .real_count(real_count),
		.imag_count(imag_count), .snapshots_seen(snapshots_seen),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the block's tables and registers.
	logic [31:0] mag_tab [MaxBins];
	logic [31:0] re_tab [MaxBins];
	logic [31:0] im_tab [MaxBins];
	logic [31:0] snap_count;
	logic [30:0] width_reg;
	logic [8:0]  bins_reg;

	request_t  pending_requests[$];
	bin_read_t expected_reads[$];
	int        mismatches;
	int        idle_cycles;
	int        burst_left;
	int        gap_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [31:0] magnitude_abs(logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	// Floor of the square root of a 64-bit value, bit-pair method.
	function automatic logic [31:0] floor_root(logic [63:0] s);
		logic [63:0] r;
		logic [63:0] b;
		r = '0;
		b = 64'h4000_0000_0000_0000;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r[31:0];
	endfunction

	function automatic int bin_index(logic [63:0] v);
		logic [63:0] q;
		int nb;
		nb = (bins_reg == 0) ? 1 : ((bins_reg > MaxBins) ? MaxBins : int'(bins_reg));
		q = (width_reg == 0) ? '1 : v / {33'd0, width_reg};
		if (q >= 64'(nb)) q = 64'(nb - 1);
		return int'(q);
	endfunction

	function automatic logic [31:0] bump(logic [31:0] c);
		return (c == '1) ? c : c + 32'd1;
	endfunction

	// Apply one accepted request to the shadow tables.
	task automatic update_histogram(request_t r);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] m;
		bin_read_t res;
		case (r.act)
			ACT_SAMPLE: begin
				a = magnitude_abs(r.re);
				b = magnitude_abs(r.im);
				m = floor_root(64'(a) * 64'(a) + 64'(b) * 64'(b));
				mag_tab[bin_index(64'(m))] = bump(mag_tab[bin_index(64'(m))]);
				re_tab[bin_index(64'(a))] = bump(re_tab[bin_index(64'(a))]);
				im_tab[bin_index(64'(b))] = bump(im_tab[bin_index(64'(b))]);
				if (r.last) snap_count = bump(snap_count);
			end
			ACT_READ: begin
				res.mag = mag_tab[r.rbin];
				res.re = re_tab[r.rbin];
				res.im = im_tab[r.rbin];
				res.snaps = snap_count;
				expected_reads.push_back(res);
			end
			ACT_CLEAR: begin
				for (int k = 0; k < MaxBins; k++) begin
					mag_tab[k] = '0;
					re_tab[k] = '0;
					im_tab[k] = '0;
				end
				snap_count = '0;
			end
			default: begin
			end
		endcase
	endtask

	// Driver: presents queued requests in bursts with random gaps. The request
	// is taken at an edge where start is high and busy low; the next one of a
	// burst follows without start dropping.
	always @(posedge clk) begin
		request_t r;
		if (start && !busy) begin
			r.act = action_t'(action);
			r.re = sample_re;
			r.im = sample_im;
			r.last = last_of_snapshot;
			r.rbin = read_bin;
			update_histogram(r);
			if (burst_left > 0 && pending_requests.size() > 0) begin
				burst_left <= burst_left - 1;
				r = pending_requests.pop_front();
				action <= r.act;
				sample_re <= r.re;
				sample_im <= r.im;
				last_of_snapshot <= r.last;
				read_bin <= r.rbin;
			end else begin
				start <= 1'b0;
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			end
		end else if (!start && arst_n) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
			end else if (pending_requests.size() > 0) begin
				r = pending_requests.pop_front();
				start <= 1'b1;
				action <= r.act;
				sample_re <= r.re;
				sample_im <= r.im;
				last_of_snapshot <= r.last;
				read_bin <= r.rbin;
				burst_left <= $urandom_range(0, 15);
			end
		end
	end

	// Monitor: every done pulse is matched against the oldest predicted read.
	// It also runs the watchdog on cycles without any handshake.
	always @(posedge clk) begin
		bin_read_t e;
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("simulation failed");
			$finish;
		end
		if (done) begin
			if (expected_reads.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected read result: got %h %h %h %h",
						magnitude_count, real_count, imag_count, snapshots_seen);
				mismatches <= mismatches + 1;
			end else begin
				e = expected_reads.pop_front();
				if (e.mag !== magnitude_count || e.re !== real_count ||
						e.im !== imag_count || e.snaps !== snapshots_seen) begin
					if (mismatches < 10)
						$display("read mismatch: exp %h %h %h %h got %h %h %h %h",
							e.mag, e.re, e.im, e.snaps, magnitude_count, real_count,
							imag_count, snapshots_seen);
					mismatches <= mismatches + 1;
				end
			end
		end
	end

	// Random sample scaled to the active range, or anywhere in the full range.
	task automatic queue_sample(logic last);
		request_t r;
		logic [63:0] span;
		span = 64'(width_reg) * 64'((bins_reg == 0) ? 1 : bins_reg) * 5 / 4;
		if (span > 64'h7FFF_FFFF || span == 0) span = 64'h7FFF_FFFF;
		r.act = ACT_SAMPLE;
		if ($urandom_range(0, 3) == 0) begin
			r.re = $urandom;
			r.im = $urandom;
		end else begin
			r.re = $urandom_range(0, 32'(span));
			r.im = $urandom_range(0, 32'(span));
			if ($urandom_range(0, 1)) r.re = -r.re;
			if ($urandom_range(0, 1)) r.im = -r.im;
		end
		r.last = last;
		r.rbin = $urandom;
		pending_requests.push_back(r);
	endtask

	task automatic queue_request(action_t a, logic [31:0] re, logic [31:0] im,
			logic last, logic [7:0] rbin);
		request_t r;
		r.act = a;
		r.re = re;
		r.im = im;
		r.last = last;
		r.rbin = rbin;
		pending_requests.push_back(r);
	endtask

	// Wait until every request is taken and every read has come back, then
	// let a clear's worth of cycles pass since samples and clears report nothing.
	task automatic drain;
		while (pending_requests.size() > 0 || start || expected_reads.size() > 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_config(logic [30:0] bw, logic [8:0] nb);
		cfg_we <= 1'b1;
		cfg_index <= CFG_BIN_WIDTH;
		cfg_data <= bw;
		@(posedge clk);
		width_reg = bw;
		cfg_index <= CFG_NUM_BINS;
		cfg_data <= {22'd0, nb};
		@(posedge clk);
		bins_reg = nb;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) queue_sample($urandom_range(0, 9) == 0);
			else if (pick < 94)
				queue_request(ACT_READ, $urandom, $urandom, $urandom_range(0, 1),
					($urandom_range(0, 1) && bins_reg != 0 && bins_reg <= MaxBins) ?
					8'($urandom_range(0, bins_reg - 1)) : 8'($urandom));
			else if (pick < 97) queue_request(ACT_CLEAR, $urandom, $urandom, 1'b1, $urandom);
			else queue_request(ACT_NONE, $urandom, $urandom, 1'b1, $urandom);
		end
		// Read back every seventeenth bin up to the top bin, then the top bin once more, before the settings change.
		for (int k = 0; k < MaxBins; k += 17)
			queue_request(ACT_READ, '0, '0, 1'b0, 8'(k));
		queue_request(ACT_READ, '0, '0, 1'b0, 8'd255);
	endtask

	initial begin
		for (int k = 0; k < MaxBins; k++) begin
			mag_tab[k] = '0;
			re_tab[k] = '0;
			im_tab[k] = '0;
		end
		snap_count = '0;
		width_reg = 31'd65536;
		bins_reg = 9'd256;
		mismatches = 0;
		idle_cycles = 0;
		burst_left = 0;
		gap_left = 0;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_SAMPLE;
		sample_re = '0;
		sample_im = '0;
		last_of_snapshot = 1'b0;
		read_bin = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_BIN_WIDTH;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// The block clears its memories after reset with busy high.
		repeat (SettleCycles) @(posedge clk);

		// Directed part at the reset settings: field extremes, every action,
		// a flag on non-sample requests and a read of the top bin.
		queue_request(ACT_SAMPLE, 32'h0000_0000, 32'h0000_0000, 1'b0, 8'd0);
		queue_request(ACT_SAMPLE, 32'h8000_0000, 32'h8000_0000, 1'b1, 8'hFF);
		queue_request(ACT_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 8'd0);
		queue_request(ACT_SAMPLE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 8'd0);
		queue_request(ACT_SAMPLE, 32'h0003_0000, 32'hFFFC_0000, 1'b0, 8'd0);
		queue_request(ACT_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'd0);
		queue_request(ACT_READ, '0, '0, 1'b0, 8'd5);
		queue_request(ACT_READ, '0, '0, 1'b0, 8'd255);
		queue_request(ACT_NONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 8'hFF);
		queue_request(ACT_READ, '0, '0, 1'b0, 8'd1);
		queue_request(ACT_CLEAR, '0, '0, 1'b1, 8'd0);
		queue_request(ACT_READ, '0, '0, 1'b0, 8'd255);
		drain();

		random_phase(150);
		drain();
		write_config(31'd0, 9'd0);          // zero width, zero bins
		random_phase(200);
		drain();
		write_config(31'h7FFF_FFFF, 9'd511); // widest bins, count above maximum
		random_phase(200);
		drain();
		write_config(31'd1, 9'd256);         // narrowest bins
		random_phase(200);
		drain();
		write_config(31'(32'd65536 * 48), 9'd16);
		random_phase(300);
		drain();
		write_config(31'($urandom_range(1, 32'h0080_0000)), 9'($urandom_range(1, 300)));
		random_phase(300);
		drain();
		write_config(31'd1, 9'd1);
		random_phase(150);
		drain();
		write_config(31'($urandom), 9'($urandom));
		random_phase(200);
		drain();

		if (mismatches == 0 && expected_reads.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
